[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the window pool RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RMWP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RMWP_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RMWP_ASSERT(label, clk, rst_n, prop, msg)
`define RMWP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[hw/rtl/rmwp_pkg.sv]
// ---------------------------------------------------------------------------
// Window pool package
// Sizes, codes and shared types of the reference counted window pool.
// ---------------------------------------------------------------------------
package rmwp_pkg;

	localparam int SLOTS      = 16;
	localparam int REF_WIDTH  = 16;
	localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W      = $clog2(SLOTS + 1);
	localparam int ADDR_W     = 32;
	localparam int SHIFT_W    = 5;
	localparam int SHIFT_MIN  = 12;
	localparam int SHIFT_MAX  = 24;
	localparam int CHUNK_W    = ADDR_W - SHIFT_MIN;
	localparam int SLOT_NUM_W = 4;
	localparam int CFG_IDX_W  = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIN_BASE    = 1'd0,
		CFG_CHUNK_SHIFT = 1'd1
	} cfg_idx_t;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NO_SLOT  = 3'd1,
		ST_RETRY    = 3'd2,
		ST_RANGE    = 3'd3,
		ST_NOT_OUT  = 3'd4,
		ST_REF_FULL = 3'd5
	} rsp_code_t;

	typedef struct packed {
		logic              pop;
		logic              push;
		logic [SLOT_W-1:0] push_slot;
	} fifo_ctl_t;

	typedef struct packed {
		logic              empty;
		logic [SLOT_W-1:0] head_slot;
	} fifo_stat_t;

endpackage

[hw/rtl/rmwp_req_if.sv]
// ---------------------------------------------------------------------------
// Window pool request channel
// Valid/ready channel that carries one get or put item.
// ---------------------------------------------------------------------------
interface rmwp_req_if;
	logic                          valid;
	logic                          ready;
	rmwp_pkg::op_t                 operation;
	logic [rmwp_pkg::ADDR_W-1:0]   phys_addr;
	logic [rmwp_pkg::ADDR_W-1:0]   virt_addr;
	logic                          wait_allowed;

	modport source (output valid, operation, phys_addr, virt_addr, wait_allowed,
		input ready);
	modport sink (input valid, operation, phys_addr, virt_addr, wait_allowed,
		output ready);
endinterface

[hw/rtl/rmwp_rsp_if.sv]
// ---------------------------------------------------------------------------
// Window pool response channel
// Valid/ready channel that carries one result item.
// ---------------------------------------------------------------------------
interface rmwp_rsp_if;
	logic                              valid;
	logic                              ready;
	rmwp_pkg::rsp_code_t               status;
	logic [rmwp_pkg::ADDR_W-1:0]       virt_addr_out;
	logic [rmwp_pkg::ADDR_W-1:0]       phys_chunk_out;
	logic [rmwp_pkg::SLOT_NUM_W-1:0]   slot_number;
	logic                              new_mapping;
	logic                              released;

	modport source (output valid, status, virt_addr_out, phys_chunk_out, slot_number,
		new_mapping, released, input ready);
	modport sink (input valid, status, virt_addr_out, phys_chunk_out, slot_number,
		new_mapping, released, output ready);
endinterface

[hw/rtl/rmwp_free_fifo.sv]
// ---------------------------------------------------------------------------
// Free slot queue
// Circular queue of idle slot numbers, oldest first, full at reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rmwp_free_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rmwp_pkg::fifo_ctl_t  ctl,
	output rmwp_pkg::fifo_stat_t stat
);
	import rmwp_pkg::*;

	logic [SLOT_W-1:0] entries_q [SLOTS];
	logic [SLOT_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;
	logic [SLOT_W:0]   tail_sum;
	logic [SLOT_W-1:0] tail;
	logic [SLOT_W-1:0] head_next;
	logic              do_push;
	logic              do_pop;

	assign do_pop  = ctl.pop && (count_q != '0);
	assign do_push = ctl.push && (count_q < CNT_W'(SLOTS));

	always_comb begin
		tail_sum = (SLOT_W + 1)'(head_q) + (SLOT_W + 1)'(count_q);
		if (tail_sum >= (SLOT_W + 1)'(SLOTS)) begin
			tail_sum = tail_sum - (SLOT_W + 1)'(SLOTS);
		end
		tail = tail_sum[SLOT_W-1:0];
		if (head_q == SLOT_W'(SLOTS - 1)) begin
			head_next = '0;
		end else begin
			head_next = head_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				entries_q[i] <= SLOT_W'(i);
			end
			head_q  <= '0;
			count_q <= CNT_W'(SLOTS);
		end else begin
			if (do_push) begin
				entries_q[tail] <= ctl.push_slot;
			end
			if (do_pop) begin
				head_q <= head_next;
			end
			count_q <= count_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

	assign stat.empty     = (count_q == '0);
	assign stat.head_slot = entries_q[head_q];

	`RMWP_ASSERT(a_pop_not_empty, clk, arst_n, ctl.pop |-> (count_q != '0), "pop from empty free queue")
	`RMWP_ASSERT(a_push_not_full, clk, arst_n, ctl.push |-> (count_q < CNT_W'(SLOTS)), "push to full free queue")
	`RMWP_ASSERT(a_pop_count, clk, arst_n, (ctl.pop && !ctl.push) |=> (count_q == $past(count_q) - 1'b1), "free count did not drop on pop")
	`RMWP_ASSERT_ALWAYS(a_count_bound, clk, !arst_n || (count_q <= CNT_W'(SLOTS)), "free count beyond slot count")

endmodule

[hw/rtl/refcounted_mapping_window_pool.sv]
// ---------------------------------------------------------------------------
// Reference counted mapping window pool
// Maps physical chunks onto a pool of virtual windows with reference counts.
// ---------------------------------------------------------------------------
// Items arrive on the req channel: a get maps a physical address into a
// window, a put hands one reference of a window back. Each item yields exactly
// one result item on the rsp channel with a status code, the window address,
// the mapped chunk, the slot number and the new mapping and released flags.
// The user must write the window base and the chunk shift through the cfg port
// only while idle; the block itself does not enforce it. An accepted item sits in
// the input stage, where the slot lookup and the state update happen; its result
// is registered in the result register and shows on rsp from there. One item per
// cycle is sustained while rsp is ready. A new item is taken while a result waits,
// as long as the input stage is empty or can drain into the result register. When
// rsp stalls, the result holds and the input stage holds its item; req.ready drops
// once both are occupied. Reset clears all references, fills the free queue with
// slots in order and sets the window base to zero and chunk_shift to twelve.
// No clearing pass is run.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module refcounted_mapping_window_pool (
	input  logic                             clk,
	input  logic                             arst_n,
	rmwp_req_if.sink                         req,
	rmwp_rsp_if.source                       rsp,
	input  logic                             cfg_wr_en,
	input  logic [rmwp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rmwp_pkg::ADDR_W-1:0]      cfg_wdata
);
	import rmwp_pkg::*;

	logic [ADDR_W-1:0]    win_base_q;
	logic [SHIFT_W-1:0]   chunk_shift_q;

	logic                 valid_s1;
	op_t                  op_s1;
	logic [ADDR_W-1:0]    phys_s1;
	logic [ADDR_W-1:0]    virt_s1;
	logic                 wait_s1;

	logic                 valid_s2;
	rsp_code_t            status_s2;
	logic [ADDR_W-1:0]    vout_s2;
	logic [ADDR_W-1:0]    pout_s2;
	logic [SLOT_NUM_W-1:0] slot_s2;
	logic                 newm_s2;
	logic                 rel_s2;

	logic [CHUNK_W-1:0]   slot_chunk_q [SLOTS];
	logic [REF_WIDTH-1:0] refcnt_q [SLOTS];

	fifo_ctl_t            fifo_ctl;
	fifo_stat_t           fifo_stat;

	logic                 advance;
	logic [SHIFT_W-1:0]   sh;
	logic [CHUNK_W-1:0]   chunk_g;
	logic [ADDR_W-1:0]    mask;
	logic [ADDR_W-1:0]    offset;
	logic [SLOTS-1:0]     hit_vec;
	logic                 hit;
	logic [SLOT_W-1:0]    hit_slot;
	logic [ADDR_W+1:0]    limit;
	logic                 in_range;
	logic [ADDR_W-1:0]    diff;
	logic [SLOT_W-1:0]    put_slot;
	logic [SLOT_W-1:0]    sel_slot;
	logic [ADDR_W-1:0]    win_addr;

	rsp_code_t            status_c;
	logic [ADDR_W-1:0]    vout_c;
	logic [ADDR_W-1:0]    pout_c;
	logic [SLOT_NUM_W-1:0] slot_c;
	logic                 newm_c;
	logic                 rel_c;
	logic                 inc_en;
	logic                 dec_en;
	logic                 install_en;

	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_base_q    <= '0;
			chunk_shift_q <= SHIFT_W'(SHIFT_MIN);
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_WIN_BASE:    win_base_q <= cfg_wdata;
				CFG_CHUNK_SHIFT: chunk_shift_q <= cfg_wdata[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (chunk_shift_q < SHIFT_W'(SHIFT_MIN)) begin
			sh = SHIFT_W'(SHIFT_MIN);
		end else if (chunk_shift_q > SHIFT_W'(SHIFT_MAX)) begin
			sh = SHIFT_W'(SHIFT_MAX);
		end else begin
			sh = chunk_shift_q;
		end
	end

	always_comb begin
		chunk_g = CHUNK_W'(phys_s1 >> sh);
		mask    = (ADDR_W'(1) << sh) - 1'b1;
		offset  = phys_s1 & mask;
		for (int i = 0; i < SLOTS; i++) begin
			hit_vec[i] = (refcnt_q[i] != '0) && (slot_chunk_q[i] == chunk_g);
		end
		hit      = 1'b0;
		hit_slot = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit      = 1'b1;
				hit_slot = SLOT_W'(i);
			end
		end
		limit    = {2'b00, win_base_q} + ((ADDR_W + 2)'(SLOTS) << sh);
		in_range = (virt_s1 >= win_base_q) && ({2'b00, virt_s1} < limit);
		diff     = virt_s1 - win_base_q;
		put_slot = SLOT_W'(diff >> sh);
		if (op_s1 == OP_PUT) begin
			sel_slot = put_slot;
		end else if (hit) begin
			sel_slot = hit_slot;
		end else begin
			sel_slot = fifo_stat.head_slot;
		end
		win_addr = win_base_q + (ADDR_W'(sel_slot) << sh) + offset;
	end

	always_comb begin
		status_c    = ST_OK;
		vout_c      = '0;
		pout_c      = '0;
		slot_c      = '0;
		newm_c      = 1'b0;
		rel_c       = 1'b0;
		inc_en      = 1'b0;
		dec_en      = 1'b0;
		install_en  = 1'b0;
		fifo_ctl.pop       = 1'b0;
		fifo_ctl.push      = 1'b0;
		fifo_ctl.push_slot = put_slot;
		if (op_s1 == OP_GET) begin
			if (hit) begin
				slot_c = SLOT_NUM_W'(hit_slot);
				pout_c = phys_s1 & ~mask;
				vout_c = win_addr;
				if (refcnt_q[hit_slot] == {REF_WIDTH{1'b1}}) begin
					status_c = ST_REF_FULL;
				end else begin
					inc_en = advance;
				end
			end else if (fifo_stat.empty) begin
				status_c = wait_s1 ? ST_RETRY : ST_NO_SLOT;
			end else begin
				slot_c       = SLOT_NUM_W'(fifo_stat.head_slot);
				pout_c       = phys_s1 & ~mask;
				vout_c       = win_addr;
				newm_c       = 1'b1;
				install_en   = advance;
				fifo_ctl.pop = advance;
			end
		end else begin
			if (!in_range) begin
				status_c = ST_RANGE;
			end else begin
				slot_c = SLOT_NUM_W'(put_slot);
				if (refcnt_q[put_slot] == '0) begin
					status_c = ST_NOT_OUT;
				end else begin
					pout_c = ADDR_W'(slot_chunk_q[put_slot]) << sh;
					dec_en = advance;
					if (refcnt_q[put_slot] == REF_WIDTH'(1)) begin
						rel_c         = 1'b1;
						fifo_ctl.push = advance;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				refcnt_q[i] <= '0;
			end
		end else begin
			if (install_en) begin
				refcnt_q[fifo_stat.head_slot] <= REF_WIDTH'(1);
			end else if (inc_en) begin
				refcnt_q[hit_slot] <= refcnt_q[hit_slot] + 1'b1;
			end else if (dec_en) begin
				refcnt_q[put_slot] <= refcnt_q[put_slot] - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (install_en) begin
			slot_chunk_q[fifo_stat.head_slot] <= chunk_g;
		end
	end

	rmwp_free_fifo u_free_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fifo_ctl),
		.stat   (fifo_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1   <= req.operation;
			phys_s1 <= req.phys_addr;
			virt_s1 <= req.virt_addr;
			wait_s1 <= req.wait_allowed;
		end
		if (advance) begin
			status_s2 <= status_c;
			vout_s2   <= vout_c;
			pout_s2   <= pout_c;
			slot_s2   <= slot_c;
			newm_s2   <= newm_c;
			rel_s2    <= rel_c;
		end
	end

	assign rsp.valid          = valid_s2;
	assign rsp.status         = status_s2;
	assign rsp.virt_addr_out  = vout_s2;
	assign rsp.phys_chunk_out = pout_s2;
	assign rsp.slot_number    = slot_s2;
	assign rsp.new_mapping    = newm_s2;
	assign rsp.released       = rel_s2;

	`RMWP_ASSERT(a_newm_ok, clk, arst_n, (rsp.valid && rsp.new_mapping) |-> (rsp.status == ST_OK), "new mapping with failing status")
	`RMWP_ASSERT(a_newm_rel, clk, arst_n, rsp.valid |-> !(rsp.new_mapping && rsp.released), "new mapping and release together")
	`RMWP_ASSERT(a_pop_idle, clk, arst_n, fifo_ctl.pop |-> (refcnt_q[fifo_stat.head_slot] == '0), "free queue handed out a referenced slot")
	`RMWP_ASSERT(a_no_overrun, clk, arst_n, (valid_s1 && !advance) |-> !req.ready, "input stage overwritten while stalled")

endmodule
